[sv/tcmo_pkg.sv]
// ----------------------------------------------------------------------------
// Text-cell mouse cursor overlay: shared package
// Item and result layouts, function codes, register indexes, and the reset
// shape of the up-arrow cursor.
// ----------------------------------------------------------------------------
package tcmo_pkg;

  localparam int unsigned ShapeRows = 16;
  localparam int unsigned ShapeIdxW = $clog2(ShapeRows);
  localparam int unsigned ShapeW    = 16;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    FUNC_MOVE    = 2'd0,
    FUNC_LOAD    = 2'd1,
    FUNC_COMPOSE = 2'd2
  } func_e;

  localparam logic CfgIdxCols = 1'b0;
  localparam logic CfgIdxRows = 1'b1;

  localparam logic [7:0] ColsRst = 8'd80;
  localparam logic [7:0] RowsRst = 8'd25;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [4:0]         row_index;
    logic [7:0]         glyph_left;
    logic [7:0]         glyph_right;
    logic [ShapeW-1:0]  clear_row;
    logic [ShapeW-1:0]  set_row;
  } item_t;

  // Position status handed from the tracker to the shape unit and the output
  typedef struct packed {
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic       cell_changed;
    logic [2:0] x_offs;
    logic [3:0] y_offs;
  } pos_stat_t;

  // Packed lowest field last so that cell_x lands in the low bits
  typedef struct packed {
    logic [7:0] out_right;
    logic [7:0] out_left;
    logic       cell_changed;
    logic [7:0] cell_y;
    logic [7:0] cell_x;
  } result_t;

  function automatic logic [ShapeW-1:0] arrow_clear(input logic [ShapeIdxW-1:0] r);
    logic [ShapeW-1:0] v;
    case (r)
      4'd0:    v = 16'hc000;
      4'd1:    v = 16'he000;
      4'd2:    v = 16'hf000;
      4'd3:    v = 16'hf800;
      4'd4:    v = 16'hfc00;
      4'd5:    v = 16'hfe00;
      4'd6:    v = 16'hff00;
      4'd7:    v = 16'hff80;
      4'd8:    v = 16'hfe00;
      4'd9:    v = 16'h1e00;
      4'd10:   v = 16'h1f00;
      4'd11:   v = 16'h0f00;
      4'd12:   v = 16'h0f00;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [ShapeW-1:0] arrow_set(input logic [ShapeIdxW-1:0] r);
    logic [ShapeW-1:0] v;
    case (r)
      4'd1:    v = 16'h4000;
      4'd2:    v = 16'h6000;
      4'd3:    v = 16'h7000;
      4'd4:    v = 16'h7800;
      4'd5:    v = 16'h7c00;
      4'd6:    v = 16'h7e00;
      4'd7:    v = 16'h6800;
      4'd8:    v = 16'h0c00;
      4'd9:    v = 16'h0c00;
      4'd10:   v = 16'h0600;
      4'd11:   v = 16'h0600;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

[sv/tcmo_pos.sv]
// ----------------------------------------------------------------------------
// Cursor position tracker
// Holds the screen size registers and the pixel position, applies clamped
// moves and reports the 1-based cell and the pixel offsets within it.
// ----------------------------------------------------------------------------
module tcmo_pos (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      move_en_i,
  input  logic                      is_move_i,
  input  logic signed [15:0]        delta_x_i,
  input  logic signed [15:0]        delta_y_i,
  output tcmo_pkg::pos_stat_t       stat_o
);

  logic [7:0]         cols_q, rows_q;
  logic [10:0]        pix_x_q, pix_x_d, pix_x_mv;
  logic [11:0]        pix_y_q, pix_y_d, pix_y_mv;
  logic signed [17:0] sum_x, top_x, sum_y, top_y;
  logic [7:0]         cell_x_old, cell_y_old, cell_x_new, cell_y_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcmo_pkg::ColsRst;
      rows_q <= tcmo_pkg::RowsRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tcmo_pkg::CfgIdxCols) cols_q <= cfg_data_i;
      if (cfg_index_i == tcmo_pkg::CfgIdxRows) rows_q <= cfg_data_i;
    end
  end

  assign sum_x = $signed({7'd0, pix_x_q}) + $signed({{2{delta_x_i[15]}}, delta_x_i});
  assign top_x = $signed({7'd0, cols_q, 3'd0}) - 18'sd2;
  assign sum_y = $signed({6'd0, pix_y_q}) + $signed({{2{delta_y_i[15]}}, delta_y_i});
  assign top_y = $signed({6'd0, rows_q, 4'd0}) - 18'sd2;

  // Clamp to the top first; an empty screen leaves a negative top, drop to 0
  always_comb begin
    if (sum_x > top_x) pix_x_mv = top_x[17] ? 11'd0 : top_x[10:0];
    else               pix_x_mv = sum_x[17] ? 11'd0 : sum_x[10:0];
    if (sum_y > top_y) pix_y_mv = top_y[17] ? 12'd0 : top_y[11:0];
    else               pix_y_mv = sum_y[17] ? 12'd0 : sum_y[11:0];
  end

  assign pix_x_d = is_move_i ? pix_x_mv : pix_x_q;
  assign pix_y_d = is_move_i ? pix_y_mv : pix_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_x_q <= '0;
      pix_y_q <= '0;
    end else if (move_en_i) begin
      pix_x_q <= pix_x_mv;
      pix_y_q <= pix_y_mv;
    end
  end

  // The last reported cell always equals the cell of the stored position
  assign cell_x_old = pix_x_q[10:3] + 8'd1;
  assign cell_y_old = pix_y_q[11:4] + 8'd1;
  assign cell_x_new = pix_x_d[10:3] + 8'd1;
  assign cell_y_new = pix_y_d[11:4] + 8'd1;

  assign stat_o.cell_x       = cell_x_new;
  assign stat_o.cell_y       = cell_y_new;
  assign stat_o.cell_changed = is_move_i &&
                               ((cell_x_new != cell_x_old) || (cell_y_new != cell_y_old));
  assign stat_o.x_offs       = pix_x_q[2:0];
  assign stat_o.y_offs       = pix_y_q[3:0];

endmodule

[sv/tcmo_shape.sv]
// ----------------------------------------------------------------------------
// Cursor shape store and glyph compositor
// Holds the AND and OR mask rows and draws the shifted cursor into one
// 16-pixel row of the glyph block.
// ----------------------------------------------------------------------------
module tcmo_shape (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_en_i,
  input  logic                              is_compose_i,
  input  logic [4:0]                        row_index_i,
  input  logic [7:0]                        glyph_left_i,
  input  logic [7:0]                        glyph_right_i,
  input  logic [tcmo_pkg::ShapeW-1:0]       clear_row_i,
  input  logic [tcmo_pkg::ShapeW-1:0]       set_row_i,
  input  tcmo_pkg::pos_stat_t               stat_i,
  output logic [7:0]                        out_left_o,
  output logic [7:0]                        out_right_o
);

  logic [tcmo_pkg::ShapeW-1:0] clear_q [tcmo_pkg::ShapeRows];
  logic [tcmo_pkg::ShapeW-1:0] set_q   [tcmo_pkg::ShapeRows];
  logic [5:0]                  diff;
  logic                        hit;
  logic [tcmo_pkg::ShapeIdxW-1:0] idx;
  logic [tcmo_pkg::ShapeW-1:0] cm, sm, g, comp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tcmo_pkg::ShapeRows; i++) begin
        clear_q[i] <= tcmo_pkg::arrow_clear(tcmo_pkg::ShapeIdxW'(i));
        set_q[i]   <= tcmo_pkg::arrow_set(tcmo_pkg::ShapeIdxW'(i));
      end
    end else if (load_en_i) begin
      clear_q[row_index_i[tcmo_pkg::ShapeIdxW-1:0]] <= clear_row_i;
      set_q[row_index_i[tcmo_pkg::ShapeIdxW-1:0]]   <= set_row_i;
    end
  end

  // Shape row under this block row; outside the shape the glyph passes
  assign diff = {1'b0, row_index_i} - {2'd0, stat_i.y_offs};
  assign hit  = !diff[5] && !diff[4];
  assign idx  = diff[tcmo_pkg::ShapeIdxW-1:0];

  assign cm   = clear_q[idx] >> stat_i.x_offs;
  assign sm   = set_q[idx] >> stat_i.x_offs;
  assign g    = {glyph_left_i, glyph_right_i};
  assign comp = hit ? ((g & ~cm) | sm) : g;

  assign out_left_o  = is_compose_i ? comp[15:8] : 8'd0;
  assign out_right_o = is_compose_i ? comp[7:0]  : 8'd0;

endmodule

[sv/text_cell_mouse_cursor_overlay_unit.sv]
// ----------------------------------------------------------------------------
// Text-cell mouse cursor overlay
// Each word passes the input register, then the result register. Throughput:
// one word per cycle while m_axis_tready holds, set by the single-pass logic
// between the two registers. Reset: position 0,0 (cell 1,1), 80x25 screen,
// up-arrow cursor shape; no clearing pass.
// ----------------------------------------------------------------------------
module text_cell_mouse_cursor_overlay_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata from bit 0: delta_x[15:0], delta_y[31:16], row_index[36:32],
  // glyph_left[44:37], glyph_right[52:45], clear_row[68:53], set_row[84:69]
  input  logic [tcmo_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: func[1:0]
  input  logic [tcmo_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata from bit 0: cell_x[7:0], cell_y[15:8], cell_changed[16],
  // out_left[24:17], out_right[32:25]
  output logic [tcmo_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  logic                 in_vld_q, out_vld_q, advance, in_acc;
  tcmo_pkg::item_t      item_q, item_d;
  tcmo_pkg::result_t    res_q, res_d;
  tcmo_pkg::pos_stat_t  stat;
  logic                 is_move, is_load, is_compose;
  logic [7:0]           out_left, out_right;

  assign item_d.func        = s_axis_tuser;
  assign item_d.delta_x     = s_axis_tdata[15:0];
  assign item_d.delta_y     = s_axis_tdata[31:16];
  assign item_d.row_index   = s_axis_tdata[36:32];
  assign item_d.glyph_left  = s_axis_tdata[44:37];
  assign item_d.glyph_right = s_axis_tdata[52:45];
  assign item_d.clear_row   = s_axis_tdata[68:53];
  assign item_d.set_row     = s_axis_tdata[84:69];

  // Advance the held word whenever the result register is free or draining
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc)       in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance)            out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc)  item_q <= item_d;
    if (advance) res_q  <= res_d;
  end

  assign is_move    = item_q.func == tcmo_pkg::FUNC_MOVE;
  assign is_load    = item_q.func == tcmo_pkg::FUNC_LOAD;
  assign is_compose = item_q.func == tcmo_pkg::FUNC_COMPOSE;

  tcmo_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .move_en_i   (advance && is_move),
    .is_move_i   (is_move),
    .delta_x_i   (item_q.delta_x),
    .delta_y_i   (item_q.delta_y),
    .stat_o      (stat)
  );

  tcmo_shape u_shape (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_en_i     (advance && is_load),
    .is_compose_i  (is_compose),
    .row_index_i   (item_q.row_index),
    .glyph_left_i  (item_q.glyph_left),
    .glyph_right_i (item_q.glyph_right),
    .clear_row_i   (item_q.clear_row),
    .set_row_i     (item_q.set_row),
    .stat_i        (stat),
    .out_left_o    (out_left),
    .out_right_o   (out_right)
  );

  assign res_d.cell_x       = stat.cell_x;
  assign res_d.cell_y       = stat.cell_y;
  assign res_d.cell_changed = stat.cell_changed;
  assign res_d.out_left     = out_left;
  assign res_d.out_right    = out_right;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(tcmo_pkg::OutDataW - $bits(tcmo_pkg::result_t))'(0), res_q};

endmodule
